FILE: hw/rtl/mpool_pkg.sv
// Shared types, constants and a helper function for the 3x3 max-pooling block.
// Used by the lane, top level and testbench files; depends on nothing else.
`default_nettype none

package mpool_pkg;

   localparam int BYTE_W           = 8;
   localparam int IN_LANES         = 8;
   localparam logic [BYTE_W-1:0] MIN_BYTE = 8'h80;

   localparam int CSR_INDEX_W      = 2;
   localparam int CSR_DATA_W       = 13;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_GROUPS = 2'd2;

   localparam int FRAME_WIDTH_W    = 7;
   localparam int FRAME_HEIGHT_W   = 13;
   localparam int CHANNEL_GROUPS_W = 6;

   localparam int FRAME_WIDTH_RESET    = 14;
   localparam int FRAME_HEIGHT_RESET   = 14;
   localparam int CHANNEL_GROUPS_RESET = 32;
   localparam int MIN_FRAME_DIM        = 3;
   localparam int MIN_GROUPS           = 1;
   localparam int WINDOW_EDGE          = 2;

   typedef struct packed {
      logic [BYTE_W-1:0] pixel;
      logic [BYTE_W-1:0] older;
      logic [BYTE_W-1:0] newer;
      logic [BYTE_W-1:0] hist_now;
      logic [BYTE_W-1:0] hist_prev;
   } lane_in_type;

   typedef struct packed {
      logic [BYTE_W-1:0] vmax;
      logic [BYTE_W-1:0] wmax;
   } lane_out_type;

   function automatic logic [BYTE_W-1:0] smax(input logic [BYTE_W-1:0] a,
                                              input logic [BYTE_W-1:0] b);
      return ($signed(a) > $signed(b)) ? a : b;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mpool_ram.sv
// Generic single-write, single-read RAM with a registered, enabled read port.
// Stand-alone; used for the row stores and the column-maximum history.
`default_nettype none

module mpool_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/mpool_lane.sv
// One pooling lane: vertical maximum of the three rows and the 3x3 window maximum.
// Depends on mpool_pkg for the lane structs and the signed maximum function.
`default_nettype none

module mpool_lane (
   input  mpool_pkg::lane_in_type  lane_in,
   output mpool_pkg::lane_out_type lane_out
);

   always_comb begin
      logic [mpool_pkg::BYTE_W-1:0] col_max;
      logic [mpool_pkg::BYTE_W-1:0] hist_max;
      col_max       = mpool_pkg::smax(lane_in.older, lane_in.newer);
      col_max       = mpool_pkg::smax(col_max, lane_in.pixel);
      hist_max      = mpool_pkg::smax(lane_in.hist_now, lane_in.hist_prev);
      lane_out.vmax = col_max;
      lane_out.wmax = mpool_pkg::smax(col_max, hist_max);
   end

endmodule

`default_nettype wire

FILE: hw/rtl/max_pool_3x3_int8_lanes_top.sv
// Accepted requests pass through the compute stage into the output register.
// Throughput: one request per cycle unless the output stalls; each request makes one
// registered read of the row stores and the history RAMs, then one write-back as it
// leaves the compute stage. Reset clears the counters, the pipeline and output valids
// and restores the default frame geometry; the RAM contents are not cleared.
// Depends on mpool_pkg, mpool_ram and mpool_lane.
`default_nettype none

module max_pool_3x3_int8_lanes_top #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_GROUPS = 32,
   parameter int LANES      = 8,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [mpool_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mpool_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [7:0]                    req_lane0,
   input  logic signed [7:0]                    req_lane1,
   input  logic signed [7:0]                    req_lane2,
   input  logic signed [7:0]                    req_lane3,
   input  logic signed [7:0]                    req_lane4,
   input  logic signed [7:0]                    req_lane5,
   input  logic signed [7:0]                    req_lane6,
   input  logic signed [7:0]                    req_lane7,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [7:0]                    rsp_max0,
   output logic signed [7:0]                    rsp_max1,
   output logic signed [7:0]                    rsp_max2,
   output logic signed [7:0]                    rsp_max3,
   output logic signed [7:0]                    rsp_max4,
   output logic signed [7:0]                    rsp_max5,
   output logic signed [7:0]                    rsp_max6,
   output logic signed [7:0]                    rsp_max7,
   output logic                                 rsp_frame_done
);

   localparam int BW         = mpool_pkg::BYTE_W;
   localparam int DW         = LANES * BW;
   localparam int CW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW         = $clog2(MAX_WIDTH + 1);
   localparam int GW         = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int GNW        = $clog2(MAX_GROUPS + 1);
   localparam int RW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int HW         = $clog2(MAX_HEIGHT + 1);
   localparam int SLOTS      = MAX_WIDTH * MAX_GROUPS;
   localparam int SAW        = $clog2(SLOTS);
   localparam int HIST_DEPTH = 2 * MAX_GROUPS;
   localparam int HAW        = $clog2(HIST_DEPTH);
   localparam int RESET_W    = (mpool_pkg::FRAME_WIDTH_RESET > MAX_WIDTH) ?
                               MAX_WIDTH : mpool_pkg::FRAME_WIDTH_RESET;
   localparam int RESET_H    = (mpool_pkg::FRAME_HEIGHT_RESET > MAX_HEIGHT) ?
                               MAX_HEIGHT : mpool_pkg::FRAME_HEIGHT_RESET;
   localparam int RESET_G    = (mpool_pkg::CHANNEL_GROUPS_RESET > MAX_GROUPS) ?
                               MAX_GROUPS : mpool_pkg::CHANNEL_GROUPS_RESET;

   // Frame geometry, held already clamped to its legal range.
   logic [WW-1:0]  width_ff,  width_in;
   logic [HW-1:0]  height_ff, height_in;
   logic [GNW-1:0] groups_ff, groups_in;
   logic           cfg_clear;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [GW-1:0] grp_ff, grp_in;

   logic accept;
   logic last_col, last_row, last_grp;
   logic [SAW-1:0] slot_addr;
   logic [HAW-1:0] hnow_addr, hprev_addr;

   logic [BW-1:0] in_lane [mpool_pkg::IN_LANES];
   logic [DW-1:0] pixel_vec;

   logic           s1_valid_ff, s1_valid_in;
   logic [DW-1:0]  s1_pixel_ff, s1_pixel_in;
   logic [SAW-1:0] s1_slot_ff, s1_slot_in;
   logic [HAW-1:0] s1_hnow_ff, s1_hnow_in;
   logic           s1_emit_ff, s1_emit_in;
   logic           s1_done_ff, s1_done_in;
   logic           s1_byp_now_ff, s1_byp_now_in;
   logic           s1_byp_prev_ff, s1_byp_prev_in;
   logic           s1_adv;

   logic [DW-1:0] byp_data_ff, byp_data_in;

   logic [DW-1:0] older_rd, newer_rd, hist_now_raw, hist_prev_raw;
   logic [DW-1:0] hist_now_rd, hist_prev_rd;
   logic [DW-1:0] vmax_vec, wmax_vec;

   logic          out_valid_ff, out_valid_in;
   logic [DW-1:0] out_max_ff, out_max_in;
   logic          out_done_ff, out_done_in;
   logic [BW-1:0] out_lane [mpool_pkg::IN_LANES];

   // Configuration registers.
   assign cfg_clear = csr_write_enable &&
                      ((csr_index == mpool_pkg::CSR_FRAME_WIDTH) ||
                       (csr_index == mpool_pkg::CSR_FRAME_HEIGHT) ||
                       (csr_index == mpool_pkg::CSR_CHANNEL_GROUPS));

   always_comb begin
      logic [mpool_pkg::FRAME_WIDTH_W-1:0]    wv;
      logic [mpool_pkg::FRAME_HEIGHT_W-1:0]   hv;
      logic [mpool_pkg::CHANNEL_GROUPS_W-1:0] gv;
      wv        = csr_write_data[mpool_pkg::FRAME_WIDTH_W-1:0];
      hv        = csr_write_data[mpool_pkg::FRAME_HEIGHT_W-1:0];
      gv        = csr_write_data[mpool_pkg::CHANNEL_GROUPS_W-1:0];
      width_in  = width_ff;
      height_in = height_ff;
      groups_in = groups_ff;
      if (csr_write_enable) begin
         case (csr_index)
            mpool_pkg::CSR_FRAME_WIDTH: begin
               if (int'(wv) < mpool_pkg::MIN_FRAME_DIM) begin
                  width_in = WW'(mpool_pkg::MIN_FRAME_DIM);
               end else if (int'(wv) > MAX_WIDTH) begin
                  width_in = WW'(MAX_WIDTH);
               end else begin
                  width_in = WW'(wv);
               end
            end
            mpool_pkg::CSR_FRAME_HEIGHT: begin
               if (int'(hv) < mpool_pkg::MIN_FRAME_DIM) begin
                  height_in = HW'(mpool_pkg::MIN_FRAME_DIM);
               end else if (int'(hv) > MAX_HEIGHT) begin
                  height_in = HW'(MAX_HEIGHT);
               end else begin
                  height_in = HW'(hv);
               end
            end
            mpool_pkg::CSR_CHANNEL_GROUPS: begin
               if (int'(gv) < mpool_pkg::MIN_GROUPS) begin
                  groups_in = GNW'(mpool_pkg::MIN_GROUPS);
               end else if (int'(gv) > MAX_GROUPS) begin
                  groups_in = GNW'(MAX_GROUPS);
               end else begin
                  groups_in = GNW'(gv);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Position counters and RAM addresses for the request being accepted.
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;

   assign last_col = (col_ff == CW'(width_ff - WW'(1)));
   assign last_row = (row_ff == RW'(height_ff - HW'(1)));
   assign last_grp = (grp_ff == GW'(groups_ff - GNW'(1)));

   assign slot_addr  = SAW'(int'(col_ff) * MAX_GROUPS + int'(grp_ff));
   assign hnow_addr  = HAW'(int'(col_ff[0]) * MAX_GROUPS + int'(grp_ff));
   assign hprev_addr = HAW'(int'(!col_ff[0]) * MAX_GROUPS + int'(grp_ff));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      grp_in = grp_ff;
      if (cfg_clear) begin
         col_in = '0;
         row_in = '0;
         grp_in = '0;
      end else if (accept) begin
         if (last_grp) begin
            grp_in = '0;
            if (last_col) begin
               col_in = '0;
               row_in = last_row ? '0 : row_ff + RW'(1);
            end else begin
               col_in = col_ff + CW'(1);
            end
         end else begin
            grp_in = grp_ff + GW'(1);
         end
      end
   end

   assign in_lane[0] = req_lane0;
   assign in_lane[1] = req_lane1;
   assign in_lane[2] = req_lane2;
   assign in_lane[3] = req_lane3;
   assign in_lane[4] = req_lane4;
   assign in_lane[5] = req_lane5;
   assign in_lane[6] = req_lane6;
   assign in_lane[7] = req_lane7;

   for (genvar k = 0; k < LANES; k++) begin : g_pixel
      if (k < mpool_pkg::IN_LANES) begin : g_real
         assign pixel_vec[k*BW +: BW] = in_lane[k];
      end else begin : g_pad
         assign pixel_vec[k*BW +: BW] = mpool_pkg::MIN_BYTE;
      end
   end

   // Compute stage: holds the request whose RAM read data is now present.
   assign s1_adv = s1_valid_ff && (!out_valid_ff || rsp_ready);

   always_comb begin
      s1_valid_in    = s1_valid_ff;
      s1_pixel_in    = s1_pixel_ff;
      s1_slot_in     = s1_slot_ff;
      s1_hnow_in     = s1_hnow_ff;
      s1_emit_in     = s1_emit_ff;
      s1_done_in     = s1_done_ff;
      s1_byp_now_in  = s1_byp_now_ff;
      s1_byp_prev_in = s1_byp_prev_ff;
      if (accept) begin
         s1_valid_in    = 1'b1;
         s1_pixel_in    = pixel_vec;
         s1_slot_in     = slot_addr;
         s1_hnow_in     = hnow_addr;
         s1_emit_in     = (int'(row_ff) >= mpool_pkg::WINDOW_EDGE) &&
                          (int'(col_ff) >= mpool_pkg::WINDOW_EDGE);
         s1_done_in     = last_row && last_col && last_grp;
         // A history write in the same cycle as the read is missed by the RAM.
         s1_byp_now_in  = s1_adv && (s1_hnow_ff == hnow_addr);
         s1_byp_prev_in = s1_adv && (s1_hnow_ff == hprev_addr);
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   assign byp_data_in  = s1_adv ? vmax_vec : byp_data_ff;
   assign hist_now_rd  = s1_byp_now_ff  ? byp_data_ff : hist_now_raw;
   assign hist_prev_rd = s1_byp_prev_ff ? byp_data_ff : hist_prev_raw;

   mpool_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_older_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_slot_ff),
      .wr_data (newer_rd),
      .rd_en   (accept),
      .rd_addr (slot_addr),
      .rd_data (older_rd)
   );

   mpool_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_newer_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_slot_ff),
      .wr_data (s1_pixel_ff),
      .rd_en   (accept),
      .rd_addr (slot_addr),
      .rd_data (newer_rd)
   );

   mpool_ram #(.WIDTH(DW), .DEPTH(HIST_DEPTH)) u_hist_now_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_hnow_ff),
      .wr_data (vmax_vec),
      .rd_en   (accept),
      .rd_addr (hnow_addr),
      .rd_data (hist_now_raw)
   );

   mpool_ram #(.WIDTH(DW), .DEPTH(HIST_DEPTH)) u_hist_prev_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_hnow_ff),
      .wr_data (vmax_vec),
      .rd_en   (accept),
      .rd_addr (hprev_addr),
      .rd_data (hist_prev_raw)
   );

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      mpool_pkg::lane_in_type  lane_in;
      mpool_pkg::lane_out_type lane_out;

      assign lane_in.pixel     = s1_pixel_ff[k*BW +: BW];
      assign lane_in.older     = older_rd[k*BW +: BW];
      assign lane_in.newer     = newer_rd[k*BW +: BW];
      assign lane_in.hist_now  = hist_now_rd[k*BW +: BW];
      assign lane_in.hist_prev = hist_prev_rd[k*BW +: BW];

      mpool_lane u_lane (
         .lane_in  (lane_in),
         .lane_out (lane_out)
      );

      assign vmax_vec[k*BW +: BW] = lane_out.vmax;
      assign wmax_vec[k*BW +: BW] = lane_out.wmax;
   end

   // Output register merging the lane results with the end-of-frame flag.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_max_in   = out_max_ff;
      out_done_in  = out_done_ff;
      if (s1_adv && s1_emit_ff) begin
         out_valid_in = 1'b1;
         out_max_in   = wmax_vec;
         out_done_in  = s1_done_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WW'(RESET_W);
         height_ff    <= HW'(RESET_H);
         groups_ff    <= GNW'(RESET_G);
         col_ff       <= '0;
         row_ff       <= '0;
         grp_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         groups_ff    <= groups_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         grp_ff       <= grp_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pixel_ff    <= s1_pixel_in;
      s1_slot_ff     <= s1_slot_in;
      s1_hnow_ff     <= s1_hnow_in;
      s1_emit_ff     <= s1_emit_in;
      s1_done_ff     <= s1_done_in;
      s1_byp_now_ff  <= s1_byp_now_in;
      s1_byp_prev_ff <= s1_byp_prev_in;
      byp_data_ff    <= byp_data_in;
      out_max_ff     <= out_max_in;
      out_done_ff    <= out_done_in;
   end

   for (genvar k = 0; k < mpool_pkg::IN_LANES; k++) begin : g_out
      if (k < LANES) begin : g_real
         assign out_lane[k] = out_max_ff[k*BW +: BW];
      end else begin : g_pad
         assign out_lane[k] = mpool_pkg::MIN_BYTE;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_frame_done = out_done_ff;
   assign rsp_max0       = $signed(out_lane[0]);
   assign rsp_max1       = $signed(out_lane[1]);
   assign rsp_max2       = $signed(out_lane[2]);
   assign rsp_max3       = $signed(out_lane[3]);
   assign rsp_max4       = $signed(out_lane[4]);
   assign rsp_max5       = $signed(out_lane[5]);
   assign rsp_max6       = $signed(out_lane[6]);
   assign rsp_max7       = $signed(out_lane[7]);

endmodule

`default_nettype wire

FILE: hw/rtl/mpool_checker.sv
// Port-level checks for the max-pooling top level, and the bind that attaches them.
// Depends only on the ports of max_pool_3x3_int8_lanes_top.
`default_nettype none

module mpool_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [7:0] rsp_max0,
   input logic              rsp_frame_done
);

   // Reset empties the pipeline, so the block is ready and shows no result.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("result shown or request refused straight after reset");

   // A newly shown result belongs to an accepted request that has passed the compute stage.
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result appeared without a request two cycles earlier");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("stalled result withdrawn");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_max0) && $stable(rsp_frame_done)))
      else $error("stalled result changed");

endmodule

bind max_pool_3x3_int8_lanes_top mpool_checker u_mpool_checker (.*);

`default_nettype wire

FILE: test/tb_max_pool_3x3_int8_lanes_top.sv
// Self-checking testbench for the streaming 3x3 max-pooling block, max_pool_3x3_int8_lanes_top.
// A clocked driver and monitor exchange requests and results with the block while a local
// window predictor tracks every accepted request; it depends on mpool_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_max_pool_3x3_int8_lanes_top;

   localparam int MAX_WIDTH     = 64;
   localparam int MAX_GROUPS    = 32;
   localparam int LANES         = 8;
   localparam int MAX_HEIGHT    = 4096;
   localparam int RANDOM_ITEMS  = 500;
   localparam int PHASE_CAP     = 200;
   localparam int SETTLE_CYCLES = 6;
   localparam int DRAIN_LIMIT   = 200000;

   localparam int BYTE_W           = mpool_pkg::BYTE_W;
   localparam int IN_LANES         = mpool_pkg::IN_LANES;
   localparam int CSR_INDEX_W      = mpool_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W       = mpool_pkg::CSR_DATA_W;
   localparam int FRAME_WIDTH_W    = mpool_pkg::FRAME_WIDTH_W;
   localparam int FRAME_HEIGHT_W   = mpool_pkg::FRAME_HEIGHT_W;
   localparam int CHANNEL_GROUPS_W = mpool_pkg::CHANNEL_GROUPS_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   typedef logic [IN_LANES-1:0][BYTE_W-1:0] lane_vec_type;

   typedef struct packed {
      lane_vec_type maxima;
      logic         frame_done;
   } pooled_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [7:0] req_lane0 = '0, req_lane1 = '0, req_lane2 = '0, req_lane3 = '0;
   logic signed [7:0] req_lane4 = '0, req_lane5 = '0, req_lane6 = '0, req_lane7 = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [7:0] rsp_max0, rsp_max1, rsp_max2, rsp_max3;
   logic signed [7:0] rsp_max4, rsp_max5, rsp_max6, rsp_max7;
   logic rsp_frame_done;
   lane_vec_type rsp_maxima;

   assign rsp_maxima = {rsp_max7, rsp_max6, rsp_max5, rsp_max4,
                        rsp_max3, rsp_max2, rsp_max1, rsp_max0};

   max_pool_3x3_int8_lanes_top #(
      .MAX_WIDTH(MAX_WIDTH),
      .MAX_GROUPS(MAX_GROUPS),
      .LANES(LANES),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_lane0(req_lane0),
      .req_lane1(req_lane1),
      .req_lane2(req_lane2),
      .req_lane3(req_lane3),
      .req_lane4(req_lane4),
      .req_lane5(req_lane5),
      .req_lane6(req_lane6),
      .req_lane7(req_lane7),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_max0(rsp_max0),
      .rsp_max1(rsp_max1),
      .rsp_max2(rsp_max2),
      .rsp_max3(rsp_max3),
      .rsp_max4(rsp_max4),
      .rsp_max5(rsp_max5),
      .rsp_max6(rsp_max6),
      .rsp_max7(rsp_max7),
      .rsp_frame_done(rsp_frame_done)
   );

   lane_vec_type older_row [MAX_WIDTH*MAX_GROUPS];
   lane_vec_type newer_row [MAX_WIDTH*MAX_GROUPS];
   lane_vec_type col_hist [2*MAX_GROUPS];
   int unsigned col_pos = 0;
   int unsigned row_pos = 0;
   int unsigned grp_pos = 0;
   int unsigned frame_width_reg  = mpool_pkg::FRAME_WIDTH_RESET;
   int unsigned frame_height_reg = mpool_pkg::FRAME_HEIGHT_RESET;
   int unsigned groups_reg       = mpool_pkg::CHANNEL_GROUPS_RESET;

   lane_vec_type pixel_queue [$];
   pooled_type window_maxima [$];
   int mismatches = 0;
   int directed_seq = 0;
   int send_gap = 0;
   int stall_left = 0;
   bit sending;
   bit idling_on = 1'b1;
   pooled_type want;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned lo,
                                             input int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic logic [7:0] larger_byte(input logic signed [7:0] a,
                                              input logic signed [7:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic int unsigned frame_items(input int unsigned w, input int unsigned h,
                                               input int unsigned g);
      return clamp_dim(w % 128, mpool_pkg::MIN_FRAME_DIM, MAX_WIDTH)
           * clamp_dim(h % 8192, mpool_pkg::MIN_FRAME_DIM, MAX_HEIGHT)
           * clamp_dim(g % 64, mpool_pkg::MIN_GROUPS, MAX_GROUPS);
   endfunction

   function automatic void pool_pixel(input lane_vec_type pix);
      int unsigned w, h, gn, slot, hnow, hprev;
      int i;
      lane_vec_type col_max, win;
      pooled_type res;
      w = clamp_dim(frame_width_reg, mpool_pkg::MIN_FRAME_DIM, MAX_WIDTH);
      h = clamp_dim(frame_height_reg, mpool_pkg::MIN_FRAME_DIM, MAX_HEIGHT);
      gn = clamp_dim(groups_reg, mpool_pkg::MIN_GROUPS, MAX_GROUPS);
      slot = col_pos * MAX_GROUPS + grp_pos;
      hnow = (col_pos % 2) * MAX_GROUPS + grp_pos;
      hprev = ((col_pos + 1) % 2) * MAX_GROUPS + grp_pos;
      for (i = 0; i < IN_LANES; i++)
         col_max[i] = larger_byte(larger_byte(older_row[slot][i], newer_row[slot][i]), pix[i]);
      older_row[slot] = newer_row[slot];
      newer_row[slot] = pix;
      if (row_pos >= mpool_pkg::WINDOW_EDGE && col_pos >= mpool_pkg::WINDOW_EDGE) begin
         for (i = 0; i < IN_LANES; i++)
            win[i] = larger_byte(col_max[i], larger_byte(col_hist[hnow][i], col_hist[hprev][i]));
         res.maxima = win;
         res.frame_done = (row_pos == h - 1) && (col_pos == w - 1) && (grp_pos == gn - 1);
         window_maxima.push_back(res);
      end
      col_hist[hnow] = col_max;
      if (grp_pos + 1 >= gn) begin
         grp_pos = 0;
         if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
         end else begin
            col_pos = col_pos + 1;
         end
      end else begin
         grp_pos = grp_pos + 1;
      end
   endfunction

   function automatic lane_vec_type directed_pixel(input int n);
      lane_vec_type p;
      int i;
      for (i = 0; i < IN_LANES; i++) begin
         case ((n + i) % 5)
            0: p[i] = mpool_pkg::MIN_BYTE;
            1: p[i] = 8'h7F;
            2: p[i] = 8'h00;
            3: p[i] = 8'hFF;
            default: p[i] = 8'h01;
         endcase
      end
      return p;
   endfunction

   function automatic lane_vec_type random_pixel();
      lane_vec_type p;
      int i;
      for (i = 0; i < IN_LANES; i++) begin
         if ($urandom_range(0, 7) == 0)
            p[i] = $urandom_range(0, 1) ? mpool_pkg::MIN_BYTE : 8'h7F;
         else
            p[i] = BYTE_W'($urandom);
      end
      return p;
   endfunction

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: mismatch: %s", $time, what);
   endtask

   task automatic wait_for_drain();
      int waited;
      waited = 0;
      while ((pixel_queue.size() != 0 || req_valid || window_maxima.size() != 0)
             && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic config_write(input logic [CSR_INDEX_W-1:0] idx,
                               input logic [CSR_DATA_W-1:0] data);
      bit restart;
      restart = 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         mpool_pkg::CSR_FRAME_WIDTH:    frame_width_reg = 32'(data[FRAME_WIDTH_W-1:0]);
         mpool_pkg::CSR_FRAME_HEIGHT:   frame_height_reg = 32'(data[FRAME_HEIGHT_W-1:0]);
         mpool_pkg::CSR_CHANNEL_GROUPS: groups_reg = 32'(data[CHANNEL_GROUPS_W-1:0]);
         default:                       restart = 1'b0;
      endcase
      if (restart) begin
         col_pos = 0;
         row_pos = 0;
         grp_pos = 0;
      end
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic configure(input int unsigned w, input int unsigned h, input int unsigned g);
      logic [CSR_DATA_W-1:0] wd, gd;
      wd = CSR_DATA_W'($urandom);
      wd[FRAME_WIDTH_W-1:0] = FRAME_WIDTH_W'(w);
      gd = CSR_DATA_W'($urandom);
      gd[CHANNEL_GROUPS_W-1:0] = CHANNEL_GROUPS_W'(g);
      wait_for_drain();
      config_write(mpool_pkg::CSR_FRAME_WIDTH, wd);
      config_write(mpool_pkg::CSR_FRAME_HEIGHT, CSR_DATA_W'(h));
      config_write(mpool_pkg::CSR_CHANNEL_GROUPS, gd);
   endtask

   task automatic queue_pixels(input int unsigned n, input bit directed);
      int unsigned k;
      for (k = 0; k < n; k++) begin
         if (directed)
            pixel_queue.push_back(directed_pixel(directed_seq++));
         else
            pixel_queue.push_back(random_pixel());
      end
   endtask

   task automatic run_phase(input int unsigned w, input int unsigned h, input int unsigned g,
                            input int unsigned n);
      configure(w, h, g);
      queue_pixels(n, 1'b0);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         sending = req_valid;
         if (req_valid && req_ready) begin
            pool_pixel(pixel_queue[0]);
            void'(pixel_queue.pop_front());
            sending = 1'b0;
         end
         if (!sending) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pixel_queue.size() != 0) begin
               if (idling_on && $urandom_range(0, 5) == 0) begin
                  send_gap = $urandom_range(0, 14);
               end else begin
                  req_lane0 <= pixel_queue[0][0];
                  req_lane1 <= pixel_queue[0][1];
                  req_lane2 <= pixel_queue[0][2];
                  req_lane3 <= pixel_queue[0][3];
                  req_lane4 <= pixel_queue[0][4];
                  req_lane5 <= pixel_queue[0][5];
                  req_lane6 <= pixel_queue[0][6];
                  req_lane7 <= pixel_queue[0][7];
                  sending = 1'b1;
               end
            end
         end
         req_valid <= sending;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (window_maxima.size() == 0) begin
               note_mismatch("result arrived with no request outstanding");
            end else begin
               want = window_maxima.pop_front();
               for (int i = 0; i < IN_LANES; i++)
                  if (rsp_maxima[i] !== want.maxima[i])
                     note_mismatch($sformatf("max%0d expected %0d, got %0d", i,
                                             $signed(want.maxima[i]), $signed(rsp_maxima[i])));
               if (rsp_frame_done !== want.frame_done)
                  note_mismatch($sformatf("frame_done expected %0b, got %0b",
                                          want.frame_done, rsp_frame_done));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 14);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      #30_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      int unsigned random_done, rw, rh, rg, n, fsize;
      random_done = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry: extreme pixels first, then one group per pixel over a whole frame
      // of the default width and height.
      queue_pixels(16, 1'b1);
      queue_pixels(80, 1'b0);
      wait_for_drain();
      config_write(mpool_pkg::CSR_CHANNEL_GROUPS, 13'd1);
      queue_pixels(mpool_pkg::FRAME_WIDTH_RESET * mpool_pkg::FRAME_HEIGHT_RESET, 1'b0);

      // Saturated minimum geometry; the spare index must not restart the frame,
      // whereas a write to a real register mid-frame must.
      configure(0, 0, 0);
      queue_pixels(4, 1'b1);
      wait_for_drain();
      config_write(CSR_SPARE_INDEX, 13'h1FFF);
      queue_pixels(8, 1'b1);
      wait_for_drain();
      config_write(mpool_pkg::CSR_FRAME_WIDTH, 13'h1F83);
      queue_pixels(9, 1'b1);

      run_phase(127, 3, 1, frame_items(127, 3, 1));
      run_phase(3, 3, 63, frame_items(3, 3, 63));
      run_phase(3, 8191, 1, 30);

      while (random_done < RANDOM_ITEMS) begin
         rw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(3, 10);
         rh = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
         rg = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 4);
         idling_on = ($urandom_range(0, 3) != 0);
         fsize = frame_items(rw, rh, rg);
         n = fsize * $urandom_range(1, 2);
         if ($urandom_range(0, 2) == 0)
            n += $urandom_range(1, fsize - 1);
         if (n > PHASE_CAP)
            n = PHASE_CAP;
         run_phase(rw, rh, rg, n);
         random_done += n;
      end

      wait_for_drain();
      idling_on = 1'b0;
      run_phase(5, 4, 3, 2 * frame_items(5, 4, 3));

      wait_for_drain();
      if (window_maxima.size() != 0 || pixel_queue.size() != 0) begin
         mismatches += window_maxima.size() + pixel_queue.size();
         $display("%0d results and %0d requests still outstanding at the end",
                  window_maxima.size(), pixel_queue.size());
      end
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/mpool_pkg.sv
hw/rtl/mpool_ram.sv
hw/rtl/mpool_lane.sv
hw/rtl/max_pool_3x3_int8_lanes_top.sv
hw/rtl/mpool_checker.sv
test/tb_max_pool_3x3_int8_lanes_top.sv
